// ===== hdl/pccl_pkg.sv =====
// ----------------------------------------------------------------------------
// pccl_pkg: shared types and constants of the pulse count code lock
// Phase codes, register indexes, result word layout and digit patterns.
// ----------------------------------------------------------------------------
package pccl_pkg;

    localparam int GAP_COUNTER_WIDTH_DEF = 16;
    localparam int GAP_TICKS_WIDTH       = 16;
    localparam int SECRET_WIDTH          = 3;
    localparam int COUNT_WIDTH           = 3;
    localparam int PHASE_WIDTH           = 3;
    localparam int SEG_WIDTH             = 7;
    localparam int CFG_INDEX_WIDTH       = 2;
    localparam int CFG_DATA_WIDTH        = 16;

    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SECRET_FIRST  = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_SECRET_SECOND = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_GAP_TICKS     = 2'd2;

    localparam logic [SECRET_WIDTH-1:0]    SECRET_FIRST_RST  = 3'd1;
    localparam logic [SECRET_WIDTH-1:0]    SECRET_SECOND_RST = 3'd2;
    localparam logic [GAP_TICKS_WIDTH-1:0] GAP_TICKS_RST     = 16'd500;

    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = 3'd4;

    localparam logic [PHASE_WIDTH-1:0] PH_WAIT1  = 3'd0;
    localparam logic [PHASE_WIDTH-1:0] PH_GAP1   = 3'd1;
    localparam logic [PHASE_WIDTH-1:0] PH_WAIT2  = 3'd2;
    localparam logic [PHASE_WIDTH-1:0] PH_GAP2   = 3'd3;
    localparam logic [PHASE_WIDTH-1:0] PH_CHECK  = 3'd4;
    localparam logic [PHASE_WIDTH-1:0] PH_UNLOCK = 3'd5;
    localparam logic [PHASE_WIDTH-1:0] PH_ERROR  = 3'd6;

    typedef struct packed {
        logic [SEG_WIDTH-1:0]   segments;
        logic                   confirm_pulse;
        logic                   unlock_pulse;
        logic                   error_pulse;
        logic [PHASE_WIDTH-1:0] phase_code;
    } result_t;

    // digit to segment pattern, bit0 = segment a; anything above four is blank
    function automatic logic [SEG_WIDTH-1:0] seg_pattern(input logic [COUNT_WIDTH-1:0] d);
        logic [SEG_WIDTH-1:0] p;
        case (d)
            3'd0:    p = 7'h3F;
            3'd1:    p = 7'h06;
            3'd2:    p = 7'h5B;
            3'd3:    p = 7'h4F;
            3'd4:    p = 7'h66;
            default: p = 7'h00;
        endcase
        return p;
    endfunction

endpackage

// ===== hdl/pulse_count_code_lock.sv =====
// ----------------------------------------------------------------------------
// pulse_count_code_lock: two-digit light pulse code lock
// Counts sensor pulses into two digits, shows them, and checks them against
// the configured secret, pulsing unlock or error.
//
//   channel | ports                                  | moves
//   --------+----------------------------------------+---------------------
//   in      | s_valid s_ready s_sensor_*             | one tick of levels
//   out     | m_valid m_ready m_segments m_*_pulse   | one result word
//           | m_phase_code                           |
//   cfg     | cfg_we cfg_index cfg_wdata             | register write
//
// One tick is taken per cycle while s_ready is high; its result word is registered in the output register.
// The state update is one pass of logic into the state registers.
// A two-slot output register parks one word while the output is stalled;
// s_ready drops only while both slots hold words.
// Reset is synchronous: entry cleared, secrets 1 and 2, gap of 500 ticks.
// ----------------------------------------------------------------------------
module pulse_count_code_lock #(
    parameter int GAP_COUNTER_WIDTH = pccl_pkg::GAP_COUNTER_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_sensor_one,
    input  logic                                 s_sensor_two,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [pccl_pkg::SEG_WIDTH-1:0]       m_segments,
    output logic                                 m_confirm_pulse,
    output logic                                 m_unlock_pulse,
    output logic                                 m_error_pulse,
    output logic [pccl_pkg::PHASE_WIDTH-1:0]     m_phase_code,
    input  logic                                 cfg_we,
    input  logic [pccl_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [pccl_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata
);
    import pccl_pkg::*;

    result_t step_result, out_word;
    logic    step;

    assign step = s_valid && s_ready;

    pccl_core #(
        .GAP_COUNTER_WIDTH(GAP_COUNTER_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step      (step),
        .sensor_one(s_sensor_one),
        .sensor_two(s_sensor_two),
        .result    (step_result)
    );

    pccl_skid u_skid (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_valid),
        .in_ready (s_ready),
        .in_data  (step_result),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_data (out_word)
    );

    assign m_segments      = out_word.segments;
    assign m_confirm_pulse = out_word.confirm_pulse;
    assign m_unlock_pulse  = out_word.unlock_pulse;
    assign m_error_pulse   = out_word.error_pulse;
    assign m_phase_code    = out_word.phase_code;

    // unlock and error both end the entry
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_unlock_pulse || m_error_pulse) |-> m_phase_code == PH_WAIT1
            && m_segments == '0)
        else $error("unlock or error word without cleared entry");

    a_one_outcome: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_unlock_pulse && m_error_pulse) && !(m_confirm_pulse
            && (m_unlock_pulse || m_error_pulse)))
        else $error("more than one pulse in a result word");

    a_confirm_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_confirm_pulse |-> (m_phase_code == PH_WAIT2 || m_phase_code == PH_CHECK)
            && m_segments != '0)
        else $error("confirm pulse outside a digit boundary");

    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output register");

endmodule

// ===== hdl/pccl_core.sv =====
// ----------------------------------------------------------------------------
// pccl_core: code lock state and configuration registers
// Computes one result word per tick from the held state and the sensor
// levels, and commits the new state when the tick is taken.
// ----------------------------------------------------------------------------
module pccl_core #(
    parameter int GAP_COUNTER_WIDTH = pccl_pkg::GAP_COUNTER_WIDTH_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [pccl_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [pccl_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    input  logic                                 step,
    input  logic                                 sensor_one,
    input  logic                                 sensor_two,
    output pccl_pkg::result_t                    result
);
    import pccl_pkg::*;

    localparam int QW = GAP_COUNTER_WIDTH;
    localparam int CW = (QW > GAP_TICKS_WIDTH) ? QW : GAP_TICKS_WIDTH;
    localparam logic [QW-1:0] QMAX = '1;

    logic [SECRET_WIDTH-1:0]    secret_first_reg, secret_second_reg;
    logic [GAP_TICKS_WIDTH-1:0] gap_ticks_reg;

    logic [PHASE_WIDTH-1:0] phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0] first_count_reg, first_count_next;
    logic [COUNT_WIDTH-1:0] second_count_reg, second_count_next;
    logic [COUNT_WIDTH-1:0] first_digit_reg, first_digit_next;
    logic [COUNT_WIDTH-1:0] second_digit_reg, second_digit_next;
    logic                   armed_one_reg, armed_one_next;
    logic                   armed_two_reg, armed_two_next;
    logic [QW-1:0]          quiet_reg, quiet_next;
    logic [SEG_WIDTH-1:0]   display_reg, display_next;

    logic [PHASE_WIDTH-1:0] phase_sensed;
    logic [QW-1:0]          quiet_inc;
    logic [CW-1:0]          gap_ext, limit;
    logic                   gap_hit;
    logic                   clear_entry;
    logic                   confirm, unlock, error;

    // the quiet gap ends at min(gap_ticks, counter maximum)
    assign gap_ext = CW'(gap_ticks_reg);
    assign limit   = (gap_ext > CW'(QMAX)) ? CW'(QMAX) : gap_ext;

    always_comb begin
        phase_next        = phase_reg;
        first_count_next  = first_count_reg;
        second_count_next = second_count_reg;
        first_digit_next  = first_digit_reg;
        second_digit_next = second_digit_reg;
        armed_one_next    = armed_one_reg;
        armed_two_next    = armed_two_reg;
        quiet_next        = quiet_reg;
        display_next      = display_reg;
        confirm           = 1'b0;
        unlock            = 1'b0;
        error             = 1'b0;
        clear_entry       = 1'b0;

        // sensor check: count armed rising levels, re-arm on low
        if (phase_reg inside {PH_WAIT1, PH_GAP1}) begin
            if (armed_one_reg && sensor_one) begin
                if (first_count_reg < COUNT_MAX) begin
                    first_count_next = first_count_reg + 3'd1;
                end
                quiet_next = '0;
                phase_next = PH_GAP1;
            end
            armed_one_next = !sensor_one;
        end
        if (phase_reg inside {PH_WAIT2, PH_GAP2}) begin
            if (armed_two_reg && sensor_two) begin
                if (second_count_reg < COUNT_MAX) begin
                    second_count_next = second_count_reg + 3'd1;
                end
                quiet_next = '0;
                phase_next = PH_GAP2;
            end
            armed_two_next = !sensor_two;
        end
        phase_sensed = phase_next;

        quiet_inc = (quiet_next == QMAX) ? quiet_next : quiet_next + 1'b1;
        gap_hit   = CW'(quiet_inc) >= limit;

        // phase step
        case (phase_sensed)
            PH_WAIT1, PH_WAIT2: begin
            end
            PH_GAP1: begin
                quiet_next = quiet_inc;
                if (gap_hit) begin
                    if (first_count_next == '0) begin
                        clear_entry = 1'b1;
                    end else begin
                        first_digit_next = first_count_next;
                        display_next     = seg_pattern(first_count_next);
                        confirm          = 1'b1;
                        quiet_next       = '0;
                        phase_next       = PH_WAIT2;
                    end
                end
            end
            PH_GAP2: begin
                quiet_next = quiet_inc;
                if (gap_hit) begin
                    if (second_count_next == '0) begin
                        clear_entry = 1'b1;
                    end else begin
                        second_digit_next = second_count_next;
                        display_next      = seg_pattern(second_count_next);
                        confirm           = 1'b1;
                        phase_next        = PH_CHECK;
                    end
                end
            end
            PH_CHECK: begin
                phase_next = (first_digit_reg == secret_first_reg &&
                              second_digit_reg == secret_second_reg) ? PH_UNLOCK : PH_ERROR;
            end
            PH_UNLOCK: begin
                unlock      = 1'b1;
                clear_entry = 1'b1;
            end
            PH_ERROR: begin
                error       = 1'b1;
                clear_entry = 1'b1;
            end
            default: begin
                clear_entry = 1'b1;
            end
        endcase

        if (clear_entry) begin
            phase_next        = PH_WAIT1;
            first_count_next  = '0;
            second_count_next = '0;
            first_digit_next  = '0;
            second_digit_next = '0;
            armed_one_next    = 1'b1;
            armed_two_next    = 1'b1;
            quiet_next        = '0;
            display_next      = '0;
        end

        result.segments      = display_next;
        result.confirm_pulse = confirm;
        result.unlock_pulse  = unlock;
        result.error_pulse   = error;
        result.phase_code    = phase_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            secret_first_reg  <= SECRET_FIRST_RST;
            secret_second_reg <= SECRET_SECOND_RST;
            gap_ticks_reg     <= GAP_TICKS_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_SECRET_FIRST:  secret_first_reg  <= cfg_wdata[SECRET_WIDTH-1:0];
                CFG_SECRET_SECOND: secret_second_reg <= cfg_wdata[SECRET_WIDTH-1:0];
                CFG_GAP_TICKS:     gap_ticks_reg     <= cfg_wdata[GAP_TICKS_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_WAIT1;
            first_count_reg  <= '0;
            second_count_reg <= '0;
            first_digit_reg  <= '0;
            second_digit_reg <= '0;
            armed_one_reg    <= 1'b1;
            armed_two_reg    <= 1'b1;
            quiet_reg        <= '0;
            display_reg      <= '0;
        end else if (step) begin
            phase_reg        <= phase_next;
            first_count_reg  <= first_count_next;
            second_count_reg <= second_count_next;
            first_digit_reg  <= first_digit_next;
            second_digit_reg <= second_digit_next;
            armed_one_reg    <= armed_one_next;
            armed_two_reg    <= armed_two_next;
            quiet_reg        <= quiet_next;
            display_reg      <= display_next;
        end
    end

endmodule

// ===== hdl/pccl_skid.sv =====
// ----------------------------------------------------------------------------
// pccl_skid: result register with skid stage
// Holds result words for the output channel; a second slot catches the word
// taken while the output is stalled.
// ----------------------------------------------------------------------------
module pccl_skid (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  pccl_pkg::result_t in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pccl_pkg::result_t out_data
);
    import pccl_pkg::*;

    logic    main_valid_reg, skid_valid_reg;
    result_t main_data_reg, skid_data_reg;
    logic    take_in, take_out;

    assign in_ready  = !skid_valid_reg;
    assign take_in   = in_valid && !skid_valid_reg;
    assign take_out  = main_valid_reg && out_ready;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            if (skid_valid_reg) begin
                if (take_out) begin
                    main_valid_reg <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
            end else if (take_in) begin
                if (main_valid_reg && !out_ready) begin
                    skid_valid_reg <= 1'b1;
                end else begin
                    main_valid_reg <= 1'b1;
                end
            end else if (take_out) begin
                main_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (take_out) begin
                main_data_reg <= skid_data_reg;
            end
        end else if (take_in) begin
            // park the word while the output is stalled
            if (main_valid_reg && !out_ready) begin
                skid_data_reg <= in_data;
            end else begin
                main_data_reg <= in_data;
            end
        end
    end

endmodule
